/* hw/rtl/arprt_pkg.sv */
`timescale 1ns / 1ps

package arprt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int ADDR_W    = 32;
    localparam int RETRY_W   = 4;
    localparam int TICK_W    = 8;
    localparam int SLOT_W    = ADDR_W + RETRY_W + TICK_W;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 2;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_TICKS = 2'd2;

    localparam logic [ADDR_W-1:0]  OWN_IP_RST      = 32'd0;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;
    localparam logic [TICK_W-1:0]  RETRY_TICKS_RST = 8'd4;

    // input op codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ARP   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result action codes
    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_GIVE_UP = 2'd1;
    localparam logic [1:0] ACT_FULL    = 2'd2;

    // classified command kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  own_ip;
        logic [RETRY_W-1:0] max_retries;
        logic [TICK_W-1:0]  retry_ticks;
    } cfg_t;

endpackage

/* hw/rtl/arprt_ram.sv */
`timescale 1ns / 1ps

module arprt_ram #(
    parameter int WIDTH = arprt_pkg::SLOT_W,
    parameter int DEPTH = arprt_pkg::ENTRIES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/arprt_front.sv */
`timescale 1ns / 1ps

module arprt_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  arprt_pkg::cfg_t             cfg,
    input  logic                        start,
    input  logic [1:0]                  op,
    input  logic [arprt_pkg::ADDR_W-1:0] addr,
    input  logic [arprt_pkg::ADDR_W-1:0] target_addr,
    output logic                        busy,
    output logic                        cmd_valid,
    output arprt_pkg::cmd_t             cmd,
    input  logic                        cmd_pop
);

    localparam int QPTR_W = (arprt_pkg::QDEPTH > 1) ? $clog2(arprt_pkg::QDEPTH) : 1;
    localparam int QCNT_W = $clog2(arprt_pkg::QDEPTH + 1);

    arprt_pkg::cmd_t     q_reg [arprt_pkg::QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    arprt_pkg::cmd_t     cls_cmd;
    logic                keep;
    logic                push;

    // classify: drop unused ops and ARP words aimed elsewhere
    always_comb
    begin
        cls_cmd.addr = addr;
        cls_cmd.kind = arprt_pkg::KIND_START;
        keep = 1'b0;
        case (op)
            arprt_pkg::OP_START:
            begin
                cls_cmd.kind = arprt_pkg::KIND_START;
                keep = 1'b1;
            end
            arprt_pkg::OP_ARP:
            begin
                cls_cmd.kind = arprt_pkg::KIND_RELEASE;
                keep = (target_addr == cfg.own_ip);
            end
            arprt_pkg::OP_TICK:
            begin
                cls_cmd.kind = arprt_pkg::KIND_TICK;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign busy      = (count_reg == QCNT_W'(arprt_pkg::QDEPTH));
    assign push      = start && !busy && keep;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(cmd_pop && cmd_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

/* hw/rtl/arprt_back.sv */
`timescale 1ns / 1ps

module arprt_back #(
    parameter int ENTRIES = arprt_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  arprt_pkg::cfg_t              cfg,
    input  logic                         cmd_valid,
    input  arprt_pkg::cmd_t              cmd,
    output logic                         cmd_pop,
    output logic                         result_valid,
    output logic [1:0]                   action,
    output logic [arprt_pkg::ADDR_W-1:0] result_addr,
    output logic                         last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int A_W   = arprt_pkg::ADDR_W;
    localparam int R_W   = arprt_pkg::RETRY_W;
    localparam int T_W   = arprt_pkg::TICK_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]            state_reg, state_next;
    arprt_pkg::cmd_t       cur_reg, cur_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  found_reg, found_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [1:0]            pend_act_reg, pend_act_next;
    logic [A_W-1:0]        pend_addr_reg, pend_addr_next;
    logic                  out_vld_reg, out_vld_next;
    logic [1:0]            out_act_reg, out_act_next;
    logic [A_W-1:0]        out_addr_reg, out_addr_next;
    logic                  out_last_reg, out_last_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [arprt_pkg::SLOT_W-1:0] ram_wdata;
    logic [arprt_pkg::SLOT_W-1:0] ram_rdata;

    logic [A_W-1:0] d_addr;
    logic [R_W-1:0] d_retries;
    logic [T_W-1:0] d_cd;
    logic           d_valid;
    logic           hit;
    logic           tick_emit;
    logic [1:0]     tick_act;

    arprt_ram #(
        .WIDTH (arprt_pkg::SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign d_addr    = ram_rdata[arprt_pkg::SLOT_W-1 -: A_W];
    assign d_retries = ram_rdata[T_W +: R_W];
    assign d_cd      = ram_rdata[T_W-1:0];
    assign d_valid   = valid_reg[proc_idx_reg];
    assign hit       = d_valid && (d_addr == cur_reg.addr);

    assign cmd_pop      = (state_reg == ST_IDLE) && cmd_valid;
    assign result_valid = out_vld_reg;
    assign action       = out_act_reg;
    assign result_addr  = out_addr_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_vld_next   = pend_vld_reg;
        pend_act_next   = pend_act_reg;
        pend_addr_next  = pend_addr_reg;
        out_vld_next    = 1'b0;
        out_act_next    = out_act_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = proc_idx_reg;
        ram_wdata       = ram_rdata;
        tick_emit       = 1'b0;
        tick_act        = arprt_pkg::ACT_SEND;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next        = cmd;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pend_vld_next   = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // issue the read for the next slot
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    proc_vld_next = 1'b1;
                    proc_idx_next = cnt_reg[IDX_W-1:0];
                end
                else if (!proc_vld_reg)
                begin
                    state_next = ST_FINISH;
                end

                // work on the slot read last cycle
                if (proc_vld_reg)
                begin
                    case (cur_reg.kind)
                        arprt_pkg::KIND_START:
                        begin
                            if (hit)
                            begin
                                found_next = 1'b1;
                            end
                            if (!d_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = proc_idx_reg;
                            end
                        end
                        arprt_pkg::KIND_RELEASE:
                        begin
                            if (hit && !found_reg)
                            begin
                                found_next               = 1'b1;
                                valid_next[proc_idx_reg] = 1'b0;
                            end
                        end
                        arprt_pkg::KIND_TICK:
                        begin
                            if (d_valid)
                            begin
                                if (d_cd > T_W'(1))
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {d_addr, d_retries, d_cd - 1'b1};
                                end
                                else if (d_retries <= R_W'(1))
                                begin
                                    valid_next[proc_idx_reg] = 1'b0;
                                    tick_emit = 1'b1;
                                    tick_act  = arprt_pkg::ACT_GIVE_UP;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {d_addr, d_retries - 1'b1, cfg.retry_ticks};
                                    tick_emit = 1'b1;
                                    tick_act  = arprt_pkg::ACT_SEND;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // hold one result back so the final one can carry last
                if (tick_emit)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_act_next  = pend_act_reg;
                        out_addr_next = pend_addr_reg;
                        out_last_next = 1'b0;
                    end
                    pend_vld_next  = 1'b1;
                    pend_act_next  = tick_act;
                    pend_addr_next = d_addr;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                case (cur_reg.kind)
                    arprt_pkg::KIND_START:
                    begin
                        if (!found_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_addr_next = cur_reg.addr;
                            out_last_next = 1'b1;
                            if (free_found_reg)
                            begin
                                ram_we                    = 1'b1;
                                ram_waddr                 = free_idx_reg;
                                ram_wdata                 = {cur_reg.addr, cfg.max_retries,
                                                             cfg.retry_ticks};
                                valid_next[free_idx_reg]  = 1'b1;
                                out_act_next              = arprt_pkg::ACT_SEND;
                            end
                            else
                            begin
                                out_act_next = arprt_pkg::ACT_FULL;
                            end
                        end
                    end
                    arprt_pkg::KIND_TICK:
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_act_next  = pend_act_reg;
                            out_addr_next = pend_addr_reg;
                            out_last_next = 1'b1;
                            pend_vld_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            proc_vld_reg   <= proc_vld_next;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        proc_idx_reg  <= proc_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_act_reg  <= pend_act_next;
        pend_addr_reg <= pend_addr_next;
        out_act_reg   <= out_act_next;
        out_addr_reg  <= out_addr_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* hw/rtl/arp_resolution_retry_tracker.sv */
`timescale 1ns / 1ps

// ARP request retry tracker.
// Input: a word (op, addr, target_addr) is taken at a rising edge with start
// high and busy low. Op 0 starts resolution of addr, op 1 reports an ARP
// packet (sender addr, target target_addr), op 2 is a timer tick.
// The front end drops unused ops and ARP words not aimed at own_ip, and
// queues the rest in a two-word queue; busy is high while that queue is full.
// The back end walks all ENTRIES slots for each queued word, one slot per
// cycle through the slot RAM's registered read port, and it pops the next
// queued word only after the walk and its finish step are done.
// Results: result_valid strobes for one cycle per result word with action,
// result_addr and last; last marks the final word caused by one input.
// A start gives one result at the end of its walk unless addr already
// holds a slot; a tick gives at most one result per cycle during its walk,
// the final one at its end. The receiver cannot stall, so results never wait.
// Configuration: wr_en, wr_index, wr_data write own_ip (0), max_retries
// (1) and retry_ticks (2); the user must do so only while the block is idle,
// which the block does not enforce. Reset empties the queue and clears all
// slot valid bits; registers return to own_ip 0, max_retries 3, retry_ticks 4.

module arp_resolution_retry_tracker #(
    parameter int ENTRIES = arprt_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic [arprt_pkg::ADDR_W-1:0]    addr,
    input  logic [arprt_pkg::ADDR_W-1:0]    target_addr,
    output logic                            result_valid,
    output logic [1:0]                      action,
    output logic [arprt_pkg::ADDR_W-1:0]    result_addr,
    output logic                            last,
    input  logic                            wr_en,
    input  logic [arprt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [arprt_pkg::ADDR_W-1:0]    wr_data
);

    arprt_pkg::cfg_t cfg_reg, cfg_next;
    arprt_pkg::cmd_t cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                arprt_pkg::REG_OWN_IP:
                begin
                    cfg_next.own_ip = wr_data;
                end
                arprt_pkg::REG_MAX_RETRIES:
                begin
                    cfg_next.max_retries = wr_data[arprt_pkg::RETRY_W-1:0];
                end
                arprt_pkg::REG_RETRY_TICKS:
                begin
                    cfg_next.retry_ticks = wr_data[arprt_pkg::TICK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip      <= arprt_pkg::OWN_IP_RST;
            cfg_reg.max_retries <= arprt_pkg::MAX_RETRIES_RST;
            cfg_reg.retry_ticks <= arprt_pkg::RETRY_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    arprt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (start),
        .op          (op),
        .addr        (addr),
        .target_addr (target_addr),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    arprt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .action       (action),
        .result_addr  (result_addr),
        .last         (last)
    );

endmodule
